>>> rtl/ablc_pkg.sv
// Shared constants, types and helpers of the ADC bit-lane calibrator.
package ablc_pkg;

    // Bytes in one frame (2..16).
    localparam int unsigned FRAME_BYTES = 16;
    localparam int unsigned POS_W       = $clog2(FRAME_BYTES);

    localparam int unsigned LANES    = 4;
    localparam int unsigned RAW_W    = 16;
    localparam int unsigned FIX_W    = 32;
    // gain (32 signed) * raw (16 unsigned) + offset fits in 49 signed bits
    localparam int unsigned CAL_W    = FIX_W + RAW_W + 1;
    // sum of two calibrated values
    localparam int unsigned SUM_W    = CAL_W + 1;
    localparam int unsigned CFG_W    = 64;
    localparam int unsigned ADDR_W   = 6;
    localparam int unsigned NUM_CAL  = 6;

    localparam logic [CFG_W-1:0] CALIB_RESET = 64'h0001_0000_0000_0000;

    typedef enum logic [2:0] {
        REG_CALIB_LANE0    = 3'd0,
        REG_CALIB_LANE1    = 3'd1,
        REG_CALIB_LANE2    = 3'd2,
        REG_CALIB_LANE3    = 3'd3,
        REG_CALIB_VOLTAGE  = 3'd4,
        REG_CALIB_PRESSURE = 3'd5,
        REG_SHUNT_THRESH   = 3'd6,
        REG_SECTION_MODE   = 3'd7
    } reg_index_t;

    typedef enum logic [1:0] {
        MODE_CASCADE  = 2'd0,
        MODE_PARALLEL = 2'd1,
        MODE_HOLD     = 2'd2,
        MODE_HOLD_ALT = 2'd3
    } section_mode_t;

    // Clamp a wide signed value to the signed 32-bit range.
    function automatic logic [FIX_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic fits;
        fits = (v[SUM_W-1:FIX_W-1] == '0) || (v[SUM_W-1:FIX_W-1] == '1);
        if (fits) begin
            return v[FIX_W-1:0];
        end else if (v[SUM_W-1]) begin
            return 32'h8000_0000;
        end else begin
            return 32'h7FFF_FFFF;
        end
    endfunction

endpackage

>>> rtl/ablc_mac.sv
// Registered calibration unit: gain * raw + offset in signed Q16.16.
module ablc_mac (
    input  logic                                  aclk,
    input  logic                                  en,
    input  logic        [ablc_pkg::CFG_W-1:0]     calib,
    input  logic        [ablc_pkg::RAW_W-1:0]     raw,
    output logic signed [ablc_pkg::CAL_W-1:0]     cal_q
);

    logic signed [ablc_pkg::FIX_W-1:0] gain;
    logic signed [ablc_pkg::FIX_W-1:0] offset;
    logic signed [ablc_pkg::RAW_W:0]   raw_s;
    logic signed [ablc_pkg::CAL_W-1:0] prod;
    logic signed [ablc_pkg::CAL_W-1:0] cal_next;
    logic signed [ablc_pkg::CAL_W-1:0] cal_reg;

    assign gain   = $signed(calib[ablc_pkg::CFG_W-1:ablc_pkg::FIX_W]);
    assign offset = $signed(calib[ablc_pkg::FIX_W-1:0]);
    assign raw_s  = $signed({1'b0, raw});

    always_comb begin
        prod     = gain * raw_s;
        cal_next = prod + ablc_pkg::CAL_W'(offset);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cal_reg <= cal_next;
        end
    end

    assign cal_q = cal_reg;

endmodule

>>> rtl/adc_bit_lane_calibrator_unit.sv
// Top level of the ADC bit-lane calibrator: APB registers, lane assembly, result pipeline.
//
// Takes one bus word per clock. Bits 3..0 of the word at frame position k
// become bit k of the raw words of lanes 0..3; s_frame_start forces position
// 0 and drops any partial frame. The last word of a frame launches a result
// down a three-register pipeline (frame capture, calibration multiply-add,
// select/saturate); the result word is driven onto the m_ channel from the
// last of these registers. Words are taken every cycle as long as the
// pipeline can move; the only thing that stops s_ready is a full pipeline
// behind a stalled m_ready. All other words only update the lane state and
// produce nothing. Calibration registers sit at byte address 8*i on the
// 64-bit APB port (lane 0..3, voltage, pressure, thresholds, mode); write
// them only while no frame result is in flight.
module adc_bit_lane_calibrator_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    // APB configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ablc_pkg::ADDR_W-1:0]        paddr,
    input  logic [ablc_pkg::CFG_W-1:0]         pwdata,
    output logic [ablc_pkg::CFG_W-1:0]         prdata,
    output logic                               pready,
    // input words
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [7:0]                         s_bus_byte,
    input  logic                               s_frame_start,
    input  logic [ablc_pkg::RAW_W-1:0]         s_voltage_raw,
    input  logic [ablc_pkg::RAW_W-1:0]         s_pressure_raw,
    // result words
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [ablc_pkg::FIX_W-1:0]  m_current_combined,
    output logic signed [ablc_pkg::FIX_W-1:0]  m_voltage_value,
    output logic signed [ablc_pkg::FIX_W-1:0]  m_pressure_value,
    output logic [ablc_pkg::RAW_W-1:0]         m_raw_lane0,
    output logic [ablc_pkg::RAW_W-1:0]         m_raw_lane1,
    output logic [ablc_pkg::RAW_W-1:0]         m_raw_lane2,
    output logic [ablc_pkg::RAW_W-1:0]         m_raw_lane3
);

    localparam logic [ablc_pkg::POS_W-1:0] LAST_POS =
        ablc_pkg::POS_W'(ablc_pkg::FRAME_BYTES - 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [ablc_pkg::CFG_W-1:0] calib_reg [ablc_pkg::NUM_CAL];
    logic [ablc_pkg::CFG_W-1:0] thresh_reg;
    ablc_pkg::section_mode_t    mode_reg;
    ablc_pkg::reg_index_t       cfg_idx;
    logic                       cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = ablc_pkg::reg_index_t'(paddr[ablc_pkg::ADDR_W-1:3]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ablc_pkg::NUM_CAL; i++) begin
                calib_reg[i] <= ablc_pkg::CALIB_RESET;
            end
            thresh_reg <= '0;
            mode_reg   <= ablc_pkg::MODE_CASCADE;
        end else if (cfg_wr) begin
            case (cfg_idx)
                ablc_pkg::REG_CALIB_LANE0:    calib_reg[0] <= pwdata;
                ablc_pkg::REG_CALIB_LANE1:    calib_reg[1] <= pwdata;
                ablc_pkg::REG_CALIB_LANE2:    calib_reg[2] <= pwdata;
                ablc_pkg::REG_CALIB_LANE3:    calib_reg[3] <= pwdata;
                ablc_pkg::REG_CALIB_VOLTAGE:  calib_reg[4] <= pwdata;
                ablc_pkg::REG_CALIB_PRESSURE: calib_reg[5] <= pwdata;
                ablc_pkg::REG_SHUNT_THRESH:   thresh_reg   <= pwdata;
                ablc_pkg::REG_SECTION_MODE:
                    mode_reg <= ablc_pkg::section_mode_t'(pwdata[1:0]);
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            ablc_pkg::REG_CALIB_LANE0:    prdata = calib_reg[0];
            ablc_pkg::REG_CALIB_LANE1:    prdata = calib_reg[1];
            ablc_pkg::REG_CALIB_LANE2:    prdata = calib_reg[2];
            ablc_pkg::REG_CALIB_LANE3:    prdata = calib_reg[3];
            ablc_pkg::REG_CALIB_VOLTAGE:  prdata = calib_reg[4];
            ablc_pkg::REG_CALIB_PRESSURE: prdata = calib_reg[5];
            ablc_pkg::REG_SHUNT_THRESH:   prdata = thresh_reg;
            ablc_pkg::REG_SECTION_MODE:   prdata = ablc_pkg::CFG_W'(mode_reg);
            default:                      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: each stage loads when empty or draining.
    // ------------------------------------------------------------------
    logic a_valid_reg;
    logic b_valid_reg;
    logic m_valid_reg;
    logic out_rdy;
    logic b_rdy;
    logic a_rdy;
    logic s_fire;

    assign out_rdy = !m_valid_reg || m_ready;
    assign b_rdy   = !b_valid_reg || out_rdy;
    assign a_rdy   = !a_valid_reg || b_rdy;
    assign s_ready = a_rdy;
    assign s_fire  = s_valid && s_ready;

    // ------------------------------------------------------------------
    // Lane assembly
    // ------------------------------------------------------------------
    logic [ablc_pkg::LANES-1:0][ablc_pkg::RAW_W-1:0] lane_reg;
    logic [ablc_pkg::LANES-1:0][ablc_pkg::RAW_W-1:0] lane_next;
    logic [ablc_pkg::POS_W-1:0]                      pos_reg;
    logic [ablc_pkg::POS_W-1:0]                      pos_next;
    logic [ablc_pkg::POS_W-1:0]                      pos_eff;
    logic                                            is_last;

    always_comb begin
        pos_eff = s_frame_start ? '0 : pos_reg;
        is_last = (pos_eff == LAST_POS);
        for (int i = 0; i < ablc_pkg::LANES; i++) begin
            lane_next[i] = ((pos_eff == '0) ? '0 : lane_reg[i])
                         | (ablc_pkg::RAW_W'(s_bus_byte[i]) << pos_eff);
        end
        pos_next = is_last ? '0 : pos_eff + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lane_reg <= '0;
            pos_reg  <= '0;
        end else if (s_fire) begin
            lane_reg <= lane_next;
            pos_reg  <= pos_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage A: captured frame
    // ------------------------------------------------------------------
    logic [ablc_pkg::LANES-1:0][ablc_pkg::RAW_W-1:0] a_lane_reg;
    logic [ablc_pkg::RAW_W-1:0]                      a_volt_reg;
    logic [ablc_pkg::RAW_W-1:0]                      a_press_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (a_rdy) begin
            a_valid_reg <= s_valid && is_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && is_last) begin
            a_lane_reg  <= lane_next;
            a_volt_reg  <= s_voltage_raw;
            a_press_reg <= s_pressure_raw;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: calibration products
    // ------------------------------------------------------------------
    logic                                            b_load;
    logic [ablc_pkg::LANES-1:0][ablc_pkg::RAW_W-1:0] b_lane_reg;
    logic signed [ablc_pkg::CAL_W-1:0]               cal [ablc_pkg::NUM_CAL];
    logic [ablc_pkg::RAW_W-1:0]                      cal_raw [ablc_pkg::NUM_CAL];

    assign b_load = a_valid_reg && b_rdy;

    always_comb begin
        for (int i = 0; i < ablc_pkg::LANES; i++) begin
            cal_raw[i] = a_lane_reg[i];
        end
        cal_raw[4] = a_volt_reg;
        cal_raw[5] = a_press_reg;
    end

    for (genvar g = 0; g < ablc_pkg::NUM_CAL; g++) begin : g_mac
        ablc_mac u_mac (
            .aclk  (aclk),
            .en    (b_load),
            .calib (calib_reg[g]),
            .raw   (cal_raw[g]),
            .cal_q (cal[g])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (b_rdy) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_load) begin
            b_lane_reg <= a_lane_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: shunt selection, saturation, result register
    // ------------------------------------------------------------------
    logic signed [ablc_pkg::CAL_W-1:0] t0;
    logic signed [ablc_pkg::CAL_W-1:0] t1;
    logic signed [ablc_pkg::CAL_W-1:0] t0x2;
    logic signed [ablc_pkg::CAL_W-1:0] casc_sel;
    logic signed [ablc_pkg::CAL_W-1:0] pair_a;
    logic signed [ablc_pkg::CAL_W-1:0] pair_b;
    logic signed [ablc_pkg::SUM_W-1:0] pair_sum;
    logic signed [ablc_pkg::SUM_W-1:0] pair_half;
    logic [ablc_pkg::FIX_W-1:0]        cur_new;
    logic [ablc_pkg::FIX_W-1:0]        cur_out;
    logic                              cur_upd;
    logic [ablc_pkg::FIX_W-1:0]        held_reg;
    logic                              c_load;

    assign c_load = b_valid_reg && out_rdy;

    always_comb begin
        t0   = ablc_pkg::CAL_W'($signed(thresh_reg[ablc_pkg::FIX_W-1:0]));
        t1   = ablc_pkg::CAL_W'($signed(thresh_reg[ablc_pkg::CFG_W-1:ablc_pkg::FIX_W]));
        t0x2 = t0 <<< 1;

        // cascaded: first lane under its threshold, else lane 2
        if (cal[0] < t0) begin
            casc_sel = cal[0];
        end else if (cal[1] < t1) begin
            casc_sel = cal[1];
        end else begin
            casc_sel = cal[2];
        end

        // parallel pairs; the arithmetic shift floors the halved sum
        pair_a    = (cal[0] >= t0x2) ? cal[1] : cal[0];
        pair_b    = (cal[2] >= t0x2) ? cal[3] : cal[2];
        pair_sum  = ablc_pkg::SUM_W'(pair_a) + ablc_pkg::SUM_W'(pair_b);
        pair_half = pair_sum >>> 1;

        case (mode_reg)
            ablc_pkg::MODE_CASCADE: begin
                cur_new = ablc_pkg::sat32(ablc_pkg::SUM_W'(casc_sel));
                cur_upd = 1'b1;
            end
            ablc_pkg::MODE_PARALLEL: begin
                cur_new = ablc_pkg::sat32(pair_half);
                cur_upd = 1'b1;
            end
            default: begin
                cur_new = held_reg;
                cur_upd = 1'b0;
            end
        endcase
        cur_out = cur_upd ? cur_new : held_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= '0;
        end else if (c_load && cur_upd) begin
            held_reg <= cur_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_rdy) begin
            m_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (c_load) begin
            m_current_combined <= $signed(cur_out);
            m_voltage_value    <= $signed(ablc_pkg::sat32(ablc_pkg::SUM_W'(cal[4])));
            m_pressure_value   <= $signed(ablc_pkg::sat32(ablc_pkg::SUM_W'(cal[5])));
            m_raw_lane0        <= b_lane_reg[0];
            m_raw_lane1        <= b_lane_reg[1];
            m_raw_lane2        <= b_lane_reg[2];
            m_raw_lane3        <= b_lane_reg[3];
        end
    end

    assign m_valid = m_valid_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
`ifndef SYNTHESIS
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= LAST_POS)
        else $error("frame position out of range");

    a_start_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_frame_start) |=> (pos_reg == ablc_pkg::POS_W'(1)))
        else $error("frame start did not restart position");

    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(b_valid_reg))
        else $error("result without a calibrated frame");

    a_stage_b_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(b_valid_reg) |-> $past(a_valid_reg))
        else $error("calibration stage loaded from empty capture");

    a_hold_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (c_load && (mode_reg == ablc_pkg::MODE_HOLD || mode_reg == ablc_pkg::MODE_HOLD_ALT))
        |=> (m_current_combined == $past(held_reg)))
        else $error("hold mode did not output held current");
`endif

endmodule

>>> tb/adc_bit_lane_calibrator_unit_test.sv
// Self-checking testbench for the ADC bit-lane calibrator: frame assembly, calibration, modes.
`timescale 1ns / 1ps

module adc_bit_lane_calibrator_unit_test;

    // One result word, in port order.
    typedef struct packed {
        logic [31:0] current;
        logic [31:0] voltage;
        logic [31:0] pressure;
        logic [15:0] raw0;
        logic [15:0] raw1;
        logic [15:0] raw2;
        logic [15:0] raw3;
    } frame_result_t;

    // One input word; 'typed' marks a row whose result is written out by hand.
    typedef struct packed {
        logic [7:0]    bus_byte;
        logic          frame_start;
        logic [15:0]   volt_raw;
        logic [15:0]   press_raw;
        bit            typed;
        frame_result_t res;
    } bus_word_t;

    localparam int          CYCLE_LIMIT = 200000;
    localparam int          PHASES      = 12;     // phase 0 runs on reset settings
    localparam int          PHASE_WORDS = 90;
    localparam int          DIRECTED_N  = 24;
    localparam int          SETTLE_CYC  = 8;      // extra settling time once no result is owed
    localparam int          HOLD_CYC    = 150;    // long m_ready hold-off
    localparam longint signed Q_MAX     = 64'sd2147483647;
    localparam longint signed Q_MIN     = -64'sd2147483648;

    logic                              aclk           = 1'b0;
    logic                              aresetn        = 1'b0;
    logic                              psel           = 1'b0;
    logic                              penable        = 1'b0;
    logic                              pwrite         = 1'b0;
    logic [ablc_pkg::ADDR_W-1:0]       paddr          = '0;
    logic [ablc_pkg::CFG_W-1:0]        pwdata         = '0;
    logic [ablc_pkg::CFG_W-1:0]        prdata;
    logic                              pready;
    logic                              s_valid        = 1'b0;
    logic                              s_ready;
    logic [7:0]                        s_bus_byte     = '0;
    logic                              s_frame_start  = 1'b0;
    logic [ablc_pkg::RAW_W-1:0]        s_voltage_raw  = '0;
    logic [ablc_pkg::RAW_W-1:0]        s_pressure_raw = '0;
    logic                              m_valid;
    logic                              m_ready        = 1'b0;
    logic signed [ablc_pkg::FIX_W-1:0] m_current_combined;
    logic signed [ablc_pkg::FIX_W-1:0] m_voltage_value;
    logic signed [ablc_pkg::FIX_W-1:0] m_pressure_value;
    logic [ablc_pkg::RAW_W-1:0]        m_raw_lane0;
    logic [ablc_pkg::RAW_W-1:0]        m_raw_lane1;
    logic [ablc_pkg::RAW_W-1:0]        m_raw_lane2;
    logic [ablc_pkg::RAW_W-1:0]        m_raw_lane3;

    adc_bit_lane_calibrator_unit DUT (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_bus_byte         (s_bus_byte),
        .s_frame_start      (s_frame_start),
        .s_voltage_raw      (s_voltage_raw),
        .s_pressure_raw     (s_pressure_raw),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_current_combined (m_current_combined),
        .m_voltage_value    (m_voltage_value),
        .m_pressure_value   (m_pressure_value),
        .m_raw_lane0        (m_raw_lane0),
        .m_raw_lane1        (m_raw_lane1),
        .m_raw_lane2        (m_raw_lane2),
        .m_raw_lane3        (m_raw_lane3)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Shadow of the register file and of the lane state
    // ------------------------------------------------------------------
    logic [63:0]             cal_regs [8];                // indexed by reg_index_t
    ablc_pkg::section_mode_t mode_reg;
    logic [15:0]             lane_acc [ablc_pkg::LANES];  // raw words being assembled
    int unsigned             frame_pos;
    logic [31:0]             held_cur;

    frame_result_t   due_frames [$];    // results still owed by the block
    bus_word_t       drv_word;          // word currently offered on s_
    int              bad_fields = 0;
    int              cycles     = 0;
    int              burst_left = 0;
    bit              steady_send = 1'b0;
    bit              hold_req    = 1'b0;

    // gain*raw + offset, exact, in Q16.16; gain in the high half, offset in the low half.
    function automatic longint signed apply_cal(input logic [63:0] packed_cal,
                                                input logic [15:0] raw);
        longint signed gain;
        longint signed offs;
        longint signed mag;
        gain = $signed(packed_cal[63:32]);
        offs = $signed(packed_cal[31:0]);
        mag  = raw;
        return gain * mag + offs;
    endfunction

    function automatic logic [31:0] clamp32(input longint signed v);
        if (v > Q_MAX) return 32'h7FFF_FFFF;
        if (v < Q_MIN) return 32'h8000_0000;
        return v[31:0];
    endfunction

    // Folds one word into the lane words; on the last byte of a frame it
    // fills r and returns 1.
    function automatic bit assemble_and_calibrate(input bus_word_t w,
                                                  output frame_result_t r);
        int unsigned   k;
        longint signed cal [ablc_pkg::LANES];
        longint signed t0;
        longint signed t1;
        longint signed pair_a;
        longint signed pair_b;
        r = '0;
        if (w.frame_start) frame_pos = 0;
        k = frame_pos;
        // position 0 always starts from clean lane words
        if (k == 0) begin
            for (int i = 0; i < ablc_pkg::LANES; i++) lane_acc[i] = '0;
        end
        for (int i = 0; i < ablc_pkg::LANES; i++) begin
            if (w.bus_byte[i]) lane_acc[i][k] = 1'b1;
        end
        if (k + 1 < ablc_pkg::FRAME_BYTES) begin
            frame_pos = k + 1;
            return 1'b0;
        end
        // frame complete; next word begins a new frame even without frame_start
        frame_pos = 0;
        for (int i = 0; i < ablc_pkg::LANES; i++) begin
            cal[i] = apply_cal(cal_regs[i], lane_acc[i]);
        end
        t0 = $signed(cal_regs[ablc_pkg::REG_SHUNT_THRESH][31:0]);
        t1 = $signed(cal_regs[ablc_pkg::REG_SHUNT_THRESH][63:32]);
        case (mode_reg)
            ablc_pkg::MODE_CASCADE: begin
                // lane 0 below T0, else lane 1 below T1, else lane 2
                if (cal[0] < t0)      held_cur = clamp32(cal[0]);
                else if (cal[1] < t1) held_cur = clamp32(cal[1]);
                else                  held_cur = clamp32(cal[2]);
            end
            ablc_pkg::MODE_PARALLEL: begin
                // halved lanes against T0 is the full lane against 2*T0;
                // the pair sum is halved once, toward minus infinity
                pair_a   = (cal[0] >= 2 * t0) ? cal[1] : cal[0];
                pair_b   = (cal[2] >= 2 * t0) ? cal[3] : cal[2];
                held_cur = clamp32((pair_a + pair_b) >>> 1);
            end
            default: ;  // hold: keep the last current
        endcase
        r.current  = held_cur;
        r.voltage  = clamp32(apply_cal(cal_regs[ablc_pkg::REG_CALIB_VOLTAGE], w.volt_raw));
        r.pressure = clamp32(apply_cal(cal_regs[ablc_pkg::REG_CALIB_PRESSURE], w.press_raw));
        r.raw0     = lane_acc[0];
        r.raw1     = lane_acc[1];
        r.raw2     = lane_acc[2];
        r.raw3     = lane_acc[3];
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Watch both channels: predict on every accepted input word, check
    // every accepted result word against the oldest prediction.
    // ------------------------------------------------------------------
    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
            bad_fields++;
        end
    endtask

    always @(posedge aclk) begin : channel_watch
        frame_result_t fresh;
        frame_result_t want;
        if (aresetn && s_valid && s_ready) begin
            if (assemble_and_calibrate(drv_word, fresh))
                due_frames.push_back(drv_word.typed ? drv_word.res : fresh);
        end
        if (aresetn && m_valid && m_ready) begin
            if (due_frames.size() == 0) begin
                $display("%0t: result word with nothing expected, got current %h",
                         $time, m_current_combined);
                bad_fields++;
            end else begin
                want = due_frames.pop_front();
                compare_field("current_combined", want.current, m_current_combined);
                compare_field("voltage_value", want.voltage, m_voltage_value);
                compare_field("pressure_value", want.pressure, m_pressure_value);
                compare_field("raw_lane0", {16'h0, want.raw0}, {16'h0, m_raw_lane0});
                compare_field("raw_lane1", {16'h0, want.raw1}, {16'h0, m_raw_lane1});
                compare_field("raw_lane2", {16'h0, want.raw2}, {16'h0, m_raw_lane2});
                compare_field("raw_lane3", {16'h0, want.raw3}, {16'h0, m_raw_lane3});
            end
        end
    end

    // Run limit.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("adc_bit_lane_calibrator_unit_test: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stall patterns, a new one picked whenever the
    // current one runs out, plus one long hold-off on request so the
    // pipeline backs up into s_ready.
    // ------------------------------------------------------------------
    int  hold_left  = 0;
    bit  hold_done  = 1'b0;
    int  pat_sel    = 0;
    int  pat_left   = 0;

    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYC;
            m_ready <= 1'b0;
        end else begin
            if (pat_left == 0) begin
                pat_sel  = $urandom_range(0, 3);
                pat_left = $urandom_range(20, 300);
            end
            pat_left = pat_left - 1;
            case (pat_sel)
                0:       m_ready <= 1'b1;                          // never stalls
                1:       m_ready <= 1'($urandom_range(0, 1));
                2:       m_ready <= ($urandom_range(0, 3) == 0);   // mostly stalled
                default: m_ready <= (cycles % 5 != 0);             // periodic bubble
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    function automatic bus_word_t plain_word(input logic [7:0] b, input logic fs,
                                             input logic [15:0] v, input logic [15:0] p);
        bus_word_t w;
        w             = '0;
        w.bus_byte    = b;
        w.frame_start = fs;
        w.volt_raw    = v;
        w.press_raw   = p;
        return w;
    endfunction

    // Offers one word and returns at the edge that takes it. Valid only
    // drops when a gap starts a new burst.
    task automatic send_word(input bus_word_t w);
        int gap;
        if (burst_left == 0) begin
            gap = steady_send ? 0
                : (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8));
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_valid        <= 1'b1;
        s_bus_byte     <= w.bus_byte;
        s_frame_start  <= w.frame_start;
        s_voltage_raw  <= w.volt_raw;
        s_pressure_raw <= w.press_raw;
        drv_word       <= w;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stop sending, let every owed result out, then give the pipeline time to empty.
    // The first edge lets the watcher book a result from the last word taken.
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (due_frames.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    // Setup and access phases, then the register is read back while the bus is idle.
    task automatic write_reg(input ablc_pkg::reg_index_t idx, input logic [63:0] val);
        logic [63:0] want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == ablc_pkg::REG_SECTION_MODE) begin
            mode_reg = ablc_pkg::section_mode_t'(val[1:0]);
        end else begin
            cal_regs[idx] = val;
        end
        @(posedge aclk);
        want = (idx == ablc_pkg::REG_SECTION_MODE) ? 64'(val[1:0]) : val;
        if (prdata !== want) begin
            $display("%0t: register %0d expected %h, got %h", $time, idx, want, prdata);
            bad_fields++;
        end
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Calibration word by style: 0 all ones, 1 zero, 2 top positive gain and
    // offset, 3 most negative gain and offset, 4 gain within +-1.0 and a random
    // offset shifted right by 0..12 bits, 5 anything, 6 reset value.
    function automatic logic [63:0] pick_calib(input int style);
        logic [31:0] g;
        logic [31:0] o;
        case (style)
            0: return '1;
            1: return '0;
            2: return {32'h7FFF_FFFF, 32'h7FFF_FFFF};
            3: return {32'h8000_0000, 32'h8000_0000};
            4: begin
                g = 32'($urandom_range(0, 32'h2_0000)) - 32'h1_0000;
                o = 32'($signed($urandom) >>> $urandom_range(0, 12));
                return {g, o};
            end
            5: return {32'($urandom), 32'($urandom)};
            default: return ablc_pkg::CALIB_RESET;
        endcase
    endfunction

    task automatic apply_settings(input int style, input logic [63:0] thr,
                                  input ablc_pkg::section_mode_t mode);
        for (int i = 0; i < ablc_pkg::NUM_CAL; i++) begin
            write_reg(ablc_pkg::reg_index_t'(i), pick_calib(style));
        end
        write_reg(ablc_pkg::REG_SHUNT_THRESH, thr);
        write_reg(ablc_pkg::REG_SECTION_MODE, 64'(mode));
    endtask

    // Random frames: mostly whole frames built from chosen lane words; now
    // and then a truncated frame or a stray frame_start inside one.
    task automatic run_frames(input int n_words);
        logic [15:0] raw [ablc_pkg::LANES];
        logic [31:0] rnd;
        bus_word_t   w;
        int          sent;
        int          len;
        bit          force_start;
        bit          broke;
        sent        = 0;
        force_start = 1'b1;
        while (sent < n_words) begin
            for (int i = 0; i < ablc_pkg::LANES; i++) begin
                case ($urandom_range(0, 5))
                    0:       raw[i] = 16'h0000;
                    1:       raw[i] = 16'hFFFF;
                    default: raw[i] = 16'($urandom);
                endcase
            end
            len   = ($urandom_range(0, 9) == 0)
                  ? $urandom_range(1, ablc_pkg::FRAME_BYTES - 1)
                  : ablc_pkg::FRAME_BYTES;
            broke = (len < ablc_pkg::FRAME_BYTES);
            for (int k = 0; k < len; k++) begin
                rnd                = $urandom;
                w                  = '0;
                w.bus_byte[7:4]    = rnd[3:0];   // ignored bits, still toggled
                for (int i = 0; i < ablc_pkg::LANES; i++) w.bus_byte[i] = raw[i][k];
                if (k == 0) begin
                    w.frame_start = force_start || rnd[4];
                end else begin
                    w.frame_start = ($urandom_range(0, 60) == 0);
                    if (w.frame_start) broke = 1'b1;
                end
                w.volt_raw  = pick_sample();
                w.press_raw = pick_sample();
                send_word(w);
                sent++;
            end
            force_start = broke;
        end
    endtask

    // ------------------------------------------------------------------
    // Directed words: an aborted partial frame, a full frame restarted by
    // frame_start (lane 0 all ones, lane 1 zero, lane 2 = 1, lane 3 = MSB
    // only, voltage at full scale so it clips), then the first words of a frame
    // that follows on without frame_start.
    // ------------------------------------------------------------------
    bus_word_t directed_tbl [DIRECTED_N];

    initial begin
        for (int i = 0; i < ablc_pkg::NUM_CAL; i++) cal_regs[i] = ablc_pkg::CALIB_RESET;
        cal_regs[ablc_pkg::REG_SHUNT_THRESH] = '0;
        cal_regs[ablc_pkg::REG_SECTION_MODE] = '0;
        mode_reg  = ablc_pkg::MODE_CASCADE;
        frame_pos = 0;
        held_cur  = '0;
        for (int i = 0; i < ablc_pkg::LANES; i++) lane_acc[i] = '0;
        drv_word  = '0;

        directed_tbl = '{
            plain_word(8'hFF, 1'b1, 16'hFFFF, 16'hFFFF),   // partial frame, dropped
            plain_word(8'h00, 1'b0, 16'h0000, 16'h0000),
            plain_word(8'hAA, 1'b0, 16'h5555, 16'hAAAA),
            plain_word(8'h55, 1'b0, 16'hAAAA, 16'h5555),
            plain_word(8'hF5, 1'b1, 16'h0000, 16'hFFFF),   // restart mid-frame
            plain_word(8'h01, 1'b0, 16'h1234, 16'h4321),
            plain_word(8'hF1, 1'b0, 16'h0001, 16'h8000),
            plain_word(8'h11, 1'b0, 16'h8000, 16'h0001),
            plain_word(8'hE1, 1'b0, 16'h7FFF, 16'hFFFE),
            plain_word(8'h21, 1'b0, 16'hFFFE, 16'h7FFF),
            plain_word(8'hD1, 1'b0, 16'h00FF, 16'hFF00),
            plain_word(8'h31, 1'b0, 16'hFF00, 16'h00FF),
            plain_word(8'hC1, 1'b0, 16'h0F0F, 16'hF0F0),
            plain_word(8'h41, 1'b0, 16'hF0F0, 16'h0F0F),
            plain_word(8'hB1, 1'b0, 16'h3333, 16'hCCCC),
            plain_word(8'h51, 1'b0, 16'hCCCC, 16'h3333),
            plain_word(8'hA1, 1'b0, 16'h6666, 16'h9999),
            plain_word(8'h61, 1'b0, 16'h9999, 16'h6666),
            plain_word(8'h91, 1'b0, 16'h0000, 16'h0000),
            plain_word(8'h09, 1'b0, 16'hFFFF, 16'h0000),   // last byte, result below
            plain_word(8'h0F, 1'b0, 16'h0000, 16'hFFFF),   // wraps: new frame, no start
            plain_word(8'hF0, 1'b0, 16'hFFFF, 16'h0000),
            plain_word(8'hFF, 1'b0, 16'h8001, 16'h7FFE),
            plain_word(8'h00, 1'b0, 16'h7FFE, 16'h8001)
        };
        // Reset settings: gain 1.0, offset 0, cascade, thresholds 0. Lane 0
        // and lane 1 are not below 0, so lane 2 (1.0) is the current; voltage
        // 0xFFFF<<16 clips to the top.
        directed_tbl[19].typed = 1'b1;
        directed_tbl[19].res   = '{32'h0001_0000, 32'h7FFF_FFFF, 32'h0000_0000,
                                   16'hFFFF, 16'h0000, 16'h0001, 16'h8000};

        // synchronous reset, held low from the start
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIRECTED_N; i++) send_word(directed_tbl[i]);
        run_frames(PHASE_WORDS);

        for (int p = 1; p < PHASES; p++) begin
            // sender waits for every owed result before touching registers
            settle();
            case (p)
                1:  apply_settings(0, '1, ablc_pkg::MODE_PARALLEL);
                2:  apply_settings(4, {32'($urandom), 32'($urandom)}, ablc_pkg::MODE_HOLD);
                3:  apply_settings(2, {32'h7FFF_FFFF, 32'h8000_0000}, ablc_pkg::MODE_CASCADE);
                4:  apply_settings(3, {32'h8000_0000, 32'h7FFF_FFFF}, ablc_pkg::MODE_PARALLEL);
                5:  apply_settings(4, {32'($urandom), 32'($urandom)}, ablc_pkg::MODE_CASCADE);
                6:  apply_settings(1, '0, ablc_pkg::MODE_HOLD_ALT);
                7:  apply_settings(5, {32'($urandom), 32'($urandom)}, ablc_pkg::MODE_PARALLEL);
                8:  apply_settings(4, {32'($urandom), 32'($urandom)}, ablc_pkg::MODE_CASCADE);
                9:  apply_settings(4, {32'($urandom), 32'($urandom)}, ablc_pkg::MODE_PARALLEL);
                10: apply_settings(4, {32'($urandom), 32'($urandom)}, ablc_pkg::MODE_HOLD);
                default: apply_settings(6, '0, ablc_pkg::MODE_CASCADE);
            endcase
            // phase 5: receiver holds off while the sender keeps streaming,
            // so the result pipeline fills and s_ready drops
            if (p == 5) begin
                steady_send = 1'b1;
                hold_req    = 1'b1;
            end
            run_frames(PHASE_WORDS);
            steady_send = 1'b0;
        end

        settle();
        if (bad_fields == 0 && due_frames.size() == 0) begin
            $display("adc_bit_lane_calibrator_unit_test: done, clean");
        end else begin
            $display("adc_bit_lane_calibrator_unit_test: done, errors");
        end
        $finish;
    end

endmodule
